### hw/rtl/mop_pkg.sv
package mop_pkg;
   localparam int PRIME_BITS  = 20;
   localparam int MAX_FACTORS = 16;
   localparam int MOD_W   = 20;
   localparam int ORDER_W = 40;
   localparam int N_W     = 2 * PRIME_BITS;
   localparam int FAC_IW  = $clog2(MAX_FACTORS);
   localparam int FAC_CW  = $clog2(MAX_FACTORS + 1);
   localparam int EXP_CW  = $clog2(N_W + 1);

   typedef enum logic [1:0] {
      ALU_NONE,
      ALU_DIV,
      ALU_MUL
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQR,
      ST_TRIAL,
      ST_TRIAL_W,
      ST_TRIAL_CHK,
      ST_STRIP,
      ST_STRIP_W,
      ST_STRIP_CHK,
      ST_TAIL,
      ST_ORD_START,
      ST_ORD_DIV,
      ST_ORD_DIV_W,
      ST_ORD_CHK,
      ST_POW_INIT,
      ST_POW_BIT,
      ST_POW_MUL,
      ST_POW_MUL_W,
      ST_POW_SQ,
      ST_POW_SQ_W,
      ST_POW_DONE,
      ST_NEXT_FAC,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic special;
      logic sqr;
      logic trial_start;
      logic trial_take;
      logic strip_start;
      logic strip_take;
      logic d_inc;
      logic fac_push_d;
      logic fac_push_rest;
      logic ord_start;
      logic ord_take;
      logic ord_accept;
      logic pow_init;
      logic mul_start;
      logic mul_take;
      logic sq_start;
      logic sq_take;
      logic exp_shift;
      logic fac_next;
   } dp_cmd_type;

   typedef struct packed {
      logic is_special;
      logic div_done;
      logic mul_done;
      logic rem_zero;
      logic d_over;
      logic rest_gt1;
      logic fac_full;
      logic fac_left;
      logic exp_zero;
      logic exp_lsb;
      logic acc_unit;
   } dp_sts_type;
endpackage

### hw/rtl/mop_divider.sv
module mop_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mop_pkg::N_W-1:0]  dividend,
   input  logic [mop_pkg::N_W-1:0]  divisor,
   output logic                     done,
   output logic [mop_pkg::N_W-1:0]  quotient,
   output logic [mop_pkg::N_W-1:0]  remainder
);
   import mop_pkg::*;

   // Restoring division, one quotient bit per cycle.
   logic [N_W-1:0]    quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [EXP_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [N_W:0]      trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[N_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = EXP_CW'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = N_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[N_W-1:0];
            quo_in = {quo_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == EXP_CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

### hw/rtl/mop_matmul.sv
module mop_matmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mop_pkg::PRIME_BITS-1:0] p,
   input  logic [mop_pkg::PRIME_BITS-1:0] xa, xb, xc, xd,
   input  logic [mop_pkg::PRIME_BITS-1:0] ya, yb, yc, yd,
   output logic                           done,
   output logic [mop_pkg::PRIME_BITS-1:0] ra, rb, rc, rd
);
   import mop_pkg::*;

   // Eight products in sequence; each product is reduced by the shared
   // divider, and pair sums by one compare and subtract.
   localparam int PW = PRIME_BITS;
   logic [2:0]      idx_ff, idx_in;
   logic [1:0]      ph_ff, ph_in;   // 0 idle, 1 multiply, 2 start divide, 3 wait
   logic            done_ff, done_in;
   logic [2*PW-1:0] prod_ff, prod_in;
   logic [PW-1:0]   half_ff, half_in;
   logic [PW-1:0]   r_ff [4];
   logic [PW-1:0]   r_in [4];
   logic [PW-1:0]   opx, opy;
   logic            dv_start, dv_done;
   logic [N_W-1:0]  dv_q, dv_r;
   logic [PW:0]     sum;

   mop_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend(N_W'(prod_ff)), .divisor(N_W'(p)),
      .done(dv_done), .quotient(dv_q), .remainder(dv_r)
   );

   always_comb begin
      unique case (idx_ff)
         3'd0: begin opx = xa; opy = ya; end
         3'd1: begin opx = xb; opy = yc; end
         3'd2: begin opx = xa; opy = yb; end
         3'd3: begin opx = xb; opy = yd; end
         3'd4: begin opx = xc; opy = ya; end
         3'd5: begin opx = xd; opy = yc; end
         3'd6: begin opx = xc; opy = yb; end
         default: begin opx = xd; opy = yd; end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      half_in  = half_ff;
      r_in     = r_ff;
      dv_start = 1'b0;
      sum      = {1'b0, half_ff} + {1'b0, dv_r[PW-1:0]};
      if (start) begin
         idx_in = '0;
         ph_in  = 2'd1;
      end else if (ph_ff == 2'd1) begin
         prod_in = opx * opy;
         ph_in   = 2'd2;
      end else if (ph_ff == 2'd2) begin
         ph_in    = 2'd3;
         dv_start = 1'b1;
      end else if (ph_ff == 2'd3) begin
         if (dv_done) begin
            if (!idx_ff[0]) begin
               half_in = dv_r[PW-1:0];
            end else begin
               r_in[idx_ff[2:1]] = (sum >= {1'b0, p}) ? PW'(sum - {1'b0, p})
                                                        : sum[PW-1:0];
            end
            if (idx_ff == 3'd7) begin
               ph_in   = 2'd0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
               ph_in  = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= 2'd0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      prod_ff <= prod_in;
      half_ff <= half_in;
      r_ff    <= r_in;
   end

   assign done = done_ff;
   assign ra = r_ff[0];
   assign rb = r_ff[1];
   assign rc = r_ff[2];
   assign rd = r_ff[3];
endmodule

### hw/rtl/mop_datapath.sv
module mop_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  mop_pkg::dp_cmd_type         cmd,
   input  logic [mop_pkg::MOD_W-1:0]   modulus,
   output mop_pkg::dp_sts_type         sts,
   output logic [mop_pkg::ORDER_W-1:0] order
);
   import mop_pkg::*;

   localparam int PW = PRIME_BITS;
   logic [PW-1:0]     p_ff;
   logic [N_W-1:0]    rest_ff, ord_ff, t_ff, ex_ff, d_ff;
   logic [ORDER_W-1:0] res_ff;
   logic [N_W-1:0]    fac_ff [MAX_FACTORS];
   logic [FAC_CW-1:0] nf_ff;
   logic [FAC_CW-1:0] fi_ff;
   logic [PW-1:0]     acc_ff [4];
   logic [PW-1:0]     sq_ff  [4];
   logic              sel_sq_ff;
   logic [N_W-1:0]    dv_a, dv_b, dv_q, dv_r;
   logic              dv_start, dv_done, mm_start, mm_done;
   logic [PW-1:0]     mx [4];
   logic [PW-1:0]     mr [4];
   logic [N_W-1:0]    cur_q;
   logic [PW-1:0]     pr [4];
   logic [N_W-1:0]    p_sq, n_next;

   assign cur_q  = fac_ff[fi_ff[FAC_IW-1:0]];
   assign p_sq   = p_ff * p_ff;
   assign n_next = p_sq - N_W'(1);

   always_comb begin
      dv_a = rest_ff;
      dv_b = d_ff;
      if (cmd.ord_start) begin
         dv_a = ord_ff;
         dv_b = cur_q;
      end
   end
   assign dv_start = cmd.trial_start | cmd.strip_start | cmd.ord_start;

   mop_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .dividend(dv_a), .divisor(dv_b),
      .done(dv_done), .quotient(dv_q), .remainder(dv_r)
   );

   // The left operand must stay selected for the whole product sequence,
   // so the choice made at start is held in a register.
   always_ff @(posedge clock) begin
      if (reset) sel_sq_ff <= 1'b0;
      else if (cmd.sq_start) sel_sq_ff <= 1'b1;
      else if (cmd.mul_start) sel_sq_ff <= 1'b0;
   end

   always_comb begin
      if (sel_sq_ff) mx = sq_ff;
      else           mx = acc_ff;
   end
   assign mm_start = cmd.mul_start | cmd.sq_start;

   mop_matmul u_mm (
      .clock(clock), .reset(reset), .start(mm_start), .p(p_ff),
      .xa(mx[0]), .xb(mx[1]), .xc(mx[2]), .xd(mx[3]),
      .ya(sq_ff[0]), .yb(sq_ff[1]), .yc(sq_ff[2]), .yd(sq_ff[3]),
      .done(mm_done), .ra(mr[0]), .rb(mr[1]), .rc(mr[2]), .rd(mr[3])
   );

   // Base matrix entries reduced mod p; only 7 can reach p for p <= 7.
   always_comb begin
      pr[0] = PW'(1);
      pr[1] = (p_ff > PW'(7)) ? PW'(7) : PW'(7 % 5);
      if (p_ff == PW'(7)) pr[1] = '0;
      else if (p_ff == PW'(6)) pr[1] = PW'(1);
      else if (p_ff == PW'(5)) pr[1] = PW'(2);
      else if (p_ff == PW'(4)) pr[1] = PW'(3);
      pr[2] = PW'(1);
      pr[3] = PW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff <= '0;
         fi_ff <= '0;
      end else begin
         if (cmd.load) begin
            nf_ff <= '0;
            fi_ff <= '0;
         end
         if ((cmd.fac_push_d || cmd.fac_push_rest) && nf_ff < FAC_CW'(MAX_FACTORS))
            nf_ff <= nf_ff + 1'b1;
         if (cmd.fac_next) fi_ff <= fi_ff + 1'b1;
      end
      if (cmd.load) begin
         p_ff <= PW'(modulus);
      end
      if (cmd.sqr) begin
         rest_ff <= n_next;
         d_ff    <= N_W'(2);
      end
      if (cmd.d_inc) d_ff <= d_ff + 1'b1;
      if (cmd.strip_take) rest_ff <= dv_q;
      if (cmd.fac_push_d) fac_ff[nf_ff[FAC_IW-1:0]] <= d_ff;
      if (cmd.fac_push_rest) fac_ff[nf_ff[FAC_IW-1:0]] <= rest_ff;
      if (cmd.trial_start) t_ff <= '0;
      if (cmd.trial_take) t_ff <= dv_q;
      if (cmd.ord_take) t_ff <= dv_q;
      if (cmd.sqr) ord_ff <= n_next;
      if (cmd.ord_accept) ord_ff <= t_ff;
      if (cmd.pow_init) begin
         ex_ff  <= t_ff;
         acc_ff <= '{PW'(1), PW'(0), PW'(0), PW'(1)};
         sq_ff  <= pr;
      end
      if (cmd.mul_take) acc_ff <= mr;
      if (cmd.sq_take)  sq_ff  <= mr;
      if (cmd.exp_shift) ex_ff <= ex_ff >> 1;
      if (cmd.special) begin
         res_ff <= (p_ff == PW'(7)) ? ORDER_W'(7) : '0;
      end else if (cmd.fac_next && !(fi_ff + 1'b1 < nf_ff)) begin
         res_ff <= ORDER_W'(ord_ff);
      end
   end

   logic [N_W-1:0] rem_hold_ff;
   always_ff @(posedge clock) begin
      if (dv_done) rem_hold_ff <= dv_r;
   end

   assign sts.is_special = (p_ff < PW'(4)) || (p_ff == PW'(7));
   assign sts.div_done   = dv_done;
   assign sts.mul_done   = mm_done;
   assign sts.rem_zero   = (rem_hold_ff == '0);
   assign sts.d_over     = (t_ff < d_ff);
   assign sts.rest_gt1   = (rest_ff > N_W'(1));
   assign sts.fac_full   = (nf_ff >= FAC_CW'(MAX_FACTORS));
   assign sts.fac_left   = (fi_ff < nf_ff);
   assign sts.exp_zero   = (ex_ff == '0);
   assign sts.exp_lsb    = ex_ff[0];
   assign sts.acc_unit   = (acc_ff[0] == PW'(1)) && (acc_ff[1] == '0)
                        && (acc_ff[2] == '0) && (acc_ff[3] == PW'(1));
   assign order = res_ff;
endmodule

### hw/rtl/mop_control.sv
module mop_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mop_pkg::dp_sts_type sts,
   output mop_pkg::dp_cmd_type cmd,
   output logic                busy,
   output logic                strobe
);
   import mop_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      strobe   = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            cmd.load = 1'b1;
            state_in = ST_SQR;
         end
         ST_SQR: if (sts.is_special) begin
            cmd.special = 1'b1;
            state_in    = ST_RESULT;
         end else begin
            cmd.sqr  = 1'b1;
            state_in = ST_TRIAL;
         end
         // Quotient rest/d is compared with d to end the trial loop.
         ST_TRIAL: begin
            cmd.trial_start = 1'b1;
            state_in        = ST_TRIAL_W;
         end
         ST_TRIAL_W: if (sts.div_done) begin
            cmd.trial_take = 1'b1;
            state_in       = ST_TRIAL_CHK;
         end
         ST_TRIAL_CHK: if (sts.d_over) begin
            state_in = ST_TAIL;
         end else if (sts.rem_zero) begin
            cmd.fac_push_d = !sts.fac_full;
            state_in       = ST_STRIP;
         end else begin
            cmd.d_inc = 1'b1;
            state_in  = ST_TRIAL;
         end
         ST_STRIP: begin
            cmd.strip_start = 1'b1;
            state_in        = ST_STRIP_W;
         end
         ST_STRIP_W: if (sts.div_done) begin
            state_in = ST_STRIP_CHK;
         end
         ST_STRIP_CHK: if (sts.rem_zero) begin
            cmd.strip_take = 1'b1;
            state_in       = ST_STRIP;
         end else begin
            cmd.d_inc = 1'b1;
            state_in  = ST_TRIAL;
         end
         ST_TAIL: begin
            cmd.fac_push_rest = sts.rest_gt1 && !sts.fac_full;
            state_in          = ST_ORD_START;
         end
         ST_ORD_START: if (sts.fac_left) state_in = ST_ORD_DIV;
                       else begin
                          cmd.fac_next = 1'b1;
                          state_in     = ST_RESULT;
                       end
         ST_ORD_DIV: begin
            cmd.ord_start = 1'b1;
            state_in      = ST_ORD_DIV_W;
         end
         ST_ORD_DIV_W: if (sts.div_done) begin
            cmd.ord_take = 1'b1;
            state_in     = ST_ORD_CHK;
         end
         ST_ORD_CHK: if (sts.rem_zero) state_in = ST_POW_INIT;
                     else                state_in = ST_NEXT_FAC;
         ST_POW_INIT: begin
            cmd.pow_init = 1'b1;
            state_in     = ST_POW_BIT;
         end
         ST_POW_BIT: if (sts.exp_zero) state_in = ST_POW_DONE;
                     else if (sts.exp_lsb) state_in = ST_POW_MUL;
                     else state_in = ST_POW_SQ;
         ST_POW_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_POW_MUL_W;
         end
         ST_POW_MUL_W: if (sts.mul_done) begin
            cmd.mul_take = 1'b1;
            state_in     = ST_POW_SQ;
         end
         ST_POW_SQ: begin
            cmd.sq_start = 1'b1;
            state_in     = ST_POW_SQ_W;
         end
         ST_POW_SQ_W: if (sts.mul_done) begin
            cmd.sq_take   = 1'b1;
            cmd.exp_shift = 1'b1;
            state_in      = ST_POW_BIT;
         end
         ST_POW_DONE: if (sts.acc_unit) begin
            cmd.ord_accept = 1'b1;
            state_in       = ST_ORD_DIV;
         end else begin
            state_in = ST_NEXT_FAC;
         end
         ST_NEXT_FAC: begin
            cmd.fac_next = 1'b1;
            state_in     = sts.fac_left ? ST_ORD_START : ST_RESULT;
         end
         ST_RESULT: begin
            strobe   = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

### hw/rtl/matrix_order_mod_prime.sv
// Channel    | Ports                      | Handshake
// request    | start, busy, req_modulus   | taken when start is high and busy low
// response   | rsp_strobe, rsp_order      | shown for one cycle, cannot be held
//
// The trial division loop runs up to about p steps of a serial divider, and
// each matrix power costs some 40 squarings of 8 products, each product
// reduced by a serial divider.
// Reset is synchronous and active high and returns the controller to idle.
// The receiver cannot stall: the result is on rsp_order while rsp_strobe is high.
module matrix_order_mod_prime (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [mop_pkg::MOD_W-1:0]   req_modulus,
   output logic                        rsp_strobe,
   output logic [mop_pkg::ORDER_W-1:0] rsp_order
);
   import mop_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // The controller sequences factoring and the power tests; the datapath
   // owns all arithmetic and storage.
   mop_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .cmd(cmd), .busy(busy), .strobe(rsp_strobe)
   );

   mop_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .modulus(req_modulus),
      .sts(sts), .order(rsp_order)
   );

   // A result can only appear while a transaction is in progress.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe outside a transaction");

   // An accepted transaction makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not set busy");

   // After a result the block is free again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("busy after result");
endmodule
